// ===== rtl/core/pnps_pkg.sv =====
// ----------------------------------------------------------------------------
// pnps_pkg
// Shared widths, defaults, the item record and the fixed-point helpers of the
// per-node power sum accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pnps_pkg;

	localparam int NODE_W        = 12;
	localparam int SAMPLE_W      = 16;
	localparam int POW_W         = 32;
	localparam int SUM_W         = 64;
	localparam int RESULT_ORDERS = 10;
	localparam int NODE_SPAN     = 1 << NODE_W;
	localparam int FRAC_SHIFT    = POW_W - 1;

	localparam int NODE_COUNT_DEF = 4096;
	localparam int MAX_ORDER_DEF  = 10;

	localparam logic signed [POW_W-1:0] POW_MAX = {1'b0, {(POW_W-1){1'b1}}};
	localparam logic signed [POW_W-1:0] POW_MIN = {1'b1, {(POW_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// One item on its way through the power pipeline. Lanes above the orders
	// formed so far hold no meaning.
	typedef struct packed {
		logic [NODE_W-1:0]                    node;
		logic [RESULT_ORDERS-1:0][POW_W-1:0] pow;
	} pnps_item_t;

	// Next power: floor(a * b / 2^31), clamped to the Q1.31 range.
	function automatic logic [POW_W-1:0] pow_step(input logic [POW_W-1:0] a,
		input logic [POW_W-1:0] b);
		logic signed [2*POW_W-1:0] prod;
		logic signed [2*POW_W-1:0] shifted;
		prod    = $signed(a) * $signed(b);
		shifted = prod >>> FRAC_SHIFT;
		if (shifted > $signed({{POW_W{1'b0}}, POW_MAX}))
			return POW_MAX;
		else if (shifted < $signed({{POW_W{1'b1}}, POW_MIN}))
			return POW_MIN;
		else
			return shifted[POW_W-1:0];
	endfunction

	// Saturating add of a Q1.31 power into a 64-bit running sum.
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
		input logic [POW_W-1:0] p);
		logic [SUM_W:0] t;
		t = {s[SUM_W-1], s} + {{(SUM_W-POW_W+1){p[POW_W-1]}}, p};
		if (t[SUM_W] != t[SUM_W-1])
			return t[SUM_W] ? SUM_MIN : SUM_MAX;
		else
			return t[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/per_node_power_sum_accumulator.sv =====
// ----------------------------------------------------------------------------
// per_node_power_sum_accumulator
// Keeps running sums of sample^1 .. sample^MAX_ORDER for every node.
//
// Input transfer: node_index and a signed Q1.15 sample on in_valid/in_ready.
// Output transfer: node_echo and the ten updated Q33.31 saturating sums on
// out_valid/out_ready; orders above MAX_ORDER read as zero. A node index of
// NODE_COUNT or more is accepted and dropped without a result.
// Items pass the power stages, a read stage and the output register. One item
// is taken every cycle while no clearing pass runs and the receiver keeps up,
// also when the same node follows itself: the rate is set by the single write
// port of the sum memory, which takes one row of all orders per cycle, and
// the power chain has one multiplier per stage after the first. After reset a
// clearing pass zeroes the min(NODE_COUNT, 4096) rows of the memory (4096 by
// default), one row a cycle; in_ready stays low until it ends. When the
// receiver stalls, results wait in the output register and the pipeline
// keeps taking items until its stages are full; then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module per_node_power_sum_accumulator #(
	parameter int NODE_COUNT = pnps_pkg::NODE_COUNT_DEF,
	parameter int MAX_ORDER  = pnps_pkg::MAX_ORDER_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  [pnps_pkg::NODE_W-1:0]           node_index,
	input  wire  signed [pnps_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [pnps_pkg::NODE_W-1:0]           node_echo,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p1,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p2,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p3,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p4,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p5,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p6,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p7,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p8,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p9,
	output logic signed [pnps_pkg::SUM_W-1:0]     sum_p10
);

	logic                  item_valid;
	logic                  item_ready;
	pnps_pkg::pnps_item_t  item;
	logic                  clearing;
	logic [pnps_pkg::RESULT_ORDERS-1:0][pnps_pkg::SUM_W-1:0] out_sum;

	pnps_power_pipe #(
		.NODE_COUNT (NODE_COUNT),
		.MAX_ORDER  (MAX_ORDER)
	) u_power_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.node_index (node_index),
		.sample     (sample),
		.hold       (clearing),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	pnps_sum_stage #(
		.NODE_COUNT (NODE_COUNT),
		.MAX_ORDER  (MAX_ORDER)
	) u_sum_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_node   (node_echo),
		.out_sum    (out_sum)
	);

	assign sum_p1  = $signed(out_sum[0]);
	assign sum_p2  = $signed(out_sum[1]);
	assign sum_p3  = $signed(out_sum[2]);
	assign sum_p4  = $signed(out_sum[3]);
	assign sum_p5  = $signed(out_sum[4]);
	assign sum_p6  = $signed(out_sum[5]);
	assign sum_p7  = $signed(out_sum[6]);
	assign sum_p8  = $signed(out_sum[7]);
	assign sum_p9  = $signed(out_sum[8]);
	assign sum_p10 = $signed(out_sum[9]);

endmodule

`default_nettype wire

// ===== rtl/core/pnps_power_pipe.sv =====
// ----------------------------------------------------------------------------
// pnps_power_pipe
// Forms sample^1 .. sample^MAX_ORDER, one multiplier per stage but stage 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pnps_power_pipe #(
	parameter int NODE_COUNT = pnps_pkg::NODE_COUNT_DEF,
	parameter int MAX_ORDER  = pnps_pkg::MAX_ORDER_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [pnps_pkg::NODE_W-1:0]     node_index,
	input  wire  signed [pnps_pkg::SAMPLE_W-1:0] sample,
	input  wire                             hold,
	output logic                            item_valid,
	output pnps_pkg::pnps_item_t            item,
	input  wire                             item_ready
);

	localparam int NS = MAX_ORDER;

	logic [NS-1:0]        vld_q;
	pnps_pkg::pnps_item_t stg_q [NS];
	logic [NS-1:0]        room;
	logic [NS-1:0]        adv;
	pnps_pkg::pnps_item_t nxt_stg [NS];
	logic                 nxt_room;
	logic                 in_fire;
	logic                 in_range;

	// Each stage moves on when the one after it has room or is moving on.
	always_comb begin
		nxt_room = item_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			room[k]  = !vld_q[k] || nxt_room;
			adv[k]   = vld_q[k] && nxt_room;
			nxt_room = room[k];
		end
	end

	assign in_ready = room[0] && !hold;
	assign in_fire  = in_valid && in_ready;
	assign in_range = 32'(node_index) < NODE_COUNT;

	always_comb begin
		nxt_stg[0]        = '0;
		nxt_stg[0].node   = node_index;
		nxt_stg[0].pow[0] = {sample, {(pnps_pkg::POW_W - pnps_pkg::SAMPLE_W){1'b0}}};
		for (int k = 1; k < NS; k++) begin
			nxt_stg[k]        = stg_q[k-1];
			nxt_stg[k].pow[k] = pnps_pkg::pow_step(stg_q[k-1].pow[k-1],
				stg_q[k-1].pow[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (room[0])
				vld_q[0] <= in_fire && in_range;
			for (int k = 1; k < NS; k++)
				if (room[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			stg_q[0] <= nxt_stg[0];
		for (int k = 1; k < NS; k++) begin
			if (adv[k-1])
				stg_q[k] <= nxt_stg[k];
		end
	end

	assign item_valid = vld_q[NS-1];
	assign item       = stg_q[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/pnps_sum_stage.sv =====
// ----------------------------------------------------------------------------
// pnps_sum_stage
// Sum memory with clearing pass, read-modify-write and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pnps_sum_stage #(
	parameter int NODE_COUNT = pnps_pkg::NODE_COUNT_DEF,
	parameter int MAX_ORDER  = pnps_pkg::MAX_ORDER_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   item_valid,
	input  pnps_pkg::pnps_item_t                  item,
	output logic                                  item_ready,
	output logic                                  clearing,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [pnps_pkg::NODE_W-1:0]           out_node,
	output logic [pnps_pkg::RESULT_ORDERS-1:0][pnps_pkg::SUM_W-1:0] out_sum
);

	localparam int DEPTH = (NODE_COUNT < pnps_pkg::NODE_SPAN) ? NODE_COUNT
		: pnps_pkg::NODE_SPAN;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic [MAX_ORDER-1:0][pnps_pkg::SUM_W-1:0] row_t;

	row_t                  sum_mem [DEPTH];
	row_t                  rdata_s2;
	pnps_pkg::pnps_item_t  item_s2;
	logic                  vld_s2;
	logic                  fwd_s2;
	logic                  out_valid_q;
	logic [pnps_pkg::NODE_W-1:0] out_node_q;
	row_t                  out_sum_q;
	logic                  clearing_q;
	logic [AW-1:0]         clr_cnt_q;

	logic                  out_room;
	logic                  adv_s2;
	logic                  take;
	row_t                  base_row;
	row_t                  new_row;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	row_t                  wr_data;

	assign out_room   = !out_valid_q || out_ready;
	assign adv_s2     = vld_s2 && out_room;
	assign item_ready = !vld_s2 || out_room;
	assign take       = item_valid && item_ready;

	// A read issued while the previous item writes the same node sees the old
	// row, so that item's result is taken from the output register instead.
	always_comb begin
		base_row = fwd_s2 ? out_sum_q : rdata_s2;
		for (int k = 0; k < MAX_ORDER; k++)
			new_row[k] = pnps_pkg::sat_add(base_row[k], item_s2.pow[k]);
	end

	assign wr_en   = clearing_q || adv_s2;
	assign wr_addr = clearing_q ? clr_cnt_q : item_s2.node[AW-1:0];
	assign wr_data = clearing_q ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (wr_en)
			sum_mem[wr_addr] <= wr_data;
		if (take)
			rdata_s2 <= sum_mem[item.node[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == AW'(DEPTH - 1))
					clearing_q <= 1'b0;
				else
					clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (item_ready)
				vld_s2 <= item_valid;
			if (out_room)
				out_valid_q <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s2 <= item;
			fwd_s2  <= adv_s2 && (item_s2.node == item.node);
		end
		if (adv_s2) begin
			out_node_q <= item_s2.node;
			out_sum_q  <= new_row;
		end
	end

	always_comb begin
		out_sum = '0;
		for (int k = 0; k < MAX_ORDER; k++)
			out_sum[k] = out_sum_q[k];
	end

	assign out_valid = out_valid_q;
	assign out_node  = out_node_q;
	assign clearing  = clearing_q;

endmodule

`default_nettype wire
